/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed");

// next-cycle implication, also checked while reset is high
`define ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/fvd_pkg.sv */
// types, sector map constants and key rom for the fat32 sector generator
// no dependencies
package fvd_pkg;

   localparam int SizeWidth  = 23;
   localparam int RomLen     = 38;
   localparam int QueueDepth = 2;

   // request and response payloads
   typedef struct packed {
      logic [23:0] block_address;
      logic [4:0]  chunk_index;
   } req_type;

   typedef struct packed {
      logic [63:0] data_high;
      logic [63:0] data_low;
   } rsp_type;

   // sector classes
   typedef logic [2:0] region_type;
   localparam region_type REGION_ZERO = 3'd0;
   localparam region_type REGION_MBR  = 3'd1;
   localparam region_type REGION_BOOT = 3'd2;
   localparam region_type REGION_FAT  = 3'd3;
   localparam region_type REGION_ROOT = 3'd4;
   localparam region_type REGION_FILE = 3'd5;

   // sector map
   localparam logic [23:0] SECT_MBR  = 24'd0;
   localparam logic [23:0] SECT_BOOT = 24'd62;
   localparam logic [23:0] SECT_FAT1 = 24'd63;
   localparam logic [23:0] SECT_FAT2 = 24'd71;
   localparam logic [23:0] SECT_ROOT = 24'd79;
   localparam logic [23:0] SECT_FILE = 24'd87;

   // classified request handed from front to back
   typedef struct packed {
      region_type  region;
      logic [4:0]  chunk;
      logic [9:0]  fat_base;
      logic [22:0] offset;
      logic        beyond_max;
   } job_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // file contents, first character in the top byte
   localparam logic [8*RomLen-1:0] KEY_ROM = "{7065c23a-3818-43c5-bdf0-55567ade31e7}";

   function automatic logic [7:0] key_byte(input logic [5:0] idx);
      int pos;
      logic [7:0] result;
      pos = RomLen - 1 - int'(idx);
      result = 8'h00;
      if (int'(idx) < RomLen) begin
         result = KEY_ROM[pos*8 +: 8];
      end
      return result;
   endfunction

endpackage

/* rtl/fat32_virtual_disk_sector_generator.sv */
// top level of the fat32 sector generator: size register, front, queue, back
// depends on fvd_pkg, fvd_front, fvd_queue, fvd_back
//
//   channel   ports                            direction  handshake
//   request   start, busy, req_data            in         start && !busy
//   response  rsp_strobe, rsp_data             out        rsp_strobe, one cycle
//   csr       csr_write_enable, csr_write_data in         csr_write_enable
//
// one request per cycle sustained; a response passes through the front stage,
// the queue entry and the output register
// synchronous reset clears the stage, queue and strobe, file_size returns to 38
// busy only rises during reset or if the queue fills, which does not happen
// since the back end drains one request every cycle
module fat32_virtual_disk_sector_generator
   import fvd_pkg::*;
#(
   parameter int KEY_BYTES = 38
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_write_enable,
   input  logic [SizeWidth-1:0] csr_write_data
);

   logic [SizeWidth-1:0] file_size_ff, file_size_in;
   queue_status_type     queue_status;
   logic                 push;
   job_type              push_job;
   job_type              head_job;

   // file size register
   assign file_size_in = csr_write_enable ? csr_write_data : file_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= SizeWidth'(38);
      end else begin
         file_size_ff <= file_size_in;
      end
   end

   fvd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_data     (req_data),
      .queue_status (queue_status),
      .busy         (busy),
      .push         (push),
      .push_job     (push_job)
   );

   fvd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (queue_status.not_empty),
      .status   (queue_status),
      .head_job (head_job)
   );

   fvd_back #(
      .KEY_BYTES (KEY_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (queue_status.not_empty),
      .job        (head_job),
      .file_size  (file_size_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* rtl/fvd_front.sv */
// front end: request stage and sector classification
// depends on fvd_pkg
module fvd_front
   import fvd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  req_type          req_data,
   input  queue_status_type queue_status,
   output logic             busy,
   output logic             push,
   output job_type          push_job
);

   logic        valid_ff, valid_in;
   req_type     req_ff, req_in;
   logic        accept;
   logic [23:0] ba;
   logic [23:0] rel_file;
   logic [23:0] rel_fat;

   // handshake
   assign busy   = reset || (valid_ff && queue_status.full);
   assign accept = start && !busy;
   assign push   = valid_ff && !queue_status.full;

   always_comb begin
      valid_in = valid_ff;
      req_in   = req_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         req_in   = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

   // classify the held request
   assign ba       = req_ff.block_address;
   assign rel_file = ba - SECT_FILE;
   assign rel_fat  = (ba < SECT_FAT2) ? (ba - SECT_FAT1) : (ba - SECT_FAT2);

   always_comb begin
      push_job.chunk      = req_ff.chunk_index;
      push_job.fat_base   = {rel_fat[2:0], req_ff.chunk_index, 2'b00};
      push_job.offset     = {rel_file[13:0], req_ff.chunk_index, 4'b0000};
      push_job.beyond_max = |rel_file[23:14];
      if (ba == SECT_MBR) begin
         push_job.region = REGION_MBR;
      end else if (ba == SECT_BOOT) begin
         push_job.region = REGION_BOOT;
      end else if (ba >= SECT_FAT1 && ba < SECT_ROOT) begin
         push_job.region = REGION_FAT;
      end else if (ba == SECT_ROOT) begin
         push_job.region = REGION_ROOT;
      end else if (ba >= SECT_FILE) begin
         push_job.region = REGION_FILE;
      end else begin
         push_job.region = REGION_ZERO;
      end
   end

endmodule

/* rtl/fvd_queue.sv */
// short queue of classified requests between front and back
// depends on fvd_pkg
module fvd_queue
   import fvd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output queue_status_type status,
   output job_type          head_job
);

   localparam int PtrWidth   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CountWidth = $clog2(QueueDepth + 1);

   job_type                 entry_ff [QueueDepth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.full      = (count_ff == CountWidth'(QueueDepth));
   assign status.not_empty = (count_ff != '0);
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;
   assign head_job         = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* rtl/fvd_back.sv */
// back end: builds one 16-byte chunk per classified request and registers it
// depends on fvd_pkg
module fvd_back
   import fvd_pkg::*;
#(
   parameter int KEY_BYTES = 38
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  job_type              job,
   input  logic [SizeWidth-1:0] file_size,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data
);

   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [7:0]  b [16];
   logic [23:0] size_round;
   logic [11:0] clusters;
   logic [12:0] chain_end;
   logic [7:0]  first_cluster;
   logic        file_hit;

   // chain length and first cluster from the file size
   assign size_round    = {1'b0, file_size} + 24'd4095;
   assign clusters      = size_round[23:12];
   assign chain_end     = {1'b0, clusters} + 13'd2;
   assign first_cluster = (file_size == '0) ? 8'd0 : 8'd3;
   assign file_hit      = !job.beyond_max && (job.offset <= file_size) &&
                          ({1'b0, job.offset[22:12]} < clusters);

   // fat entry for cluster number n
   function automatic logic [31:0] fat_entry(input logic [9:0] n, input logic [12:0] last);
      logic [31:0] value;
      value = 32'h0;
      if (n < 10'd2) begin
         value = 32'hFFFF_FFF8;
      end else if (n == 10'd2) begin
         value = 32'hFFFF_FFFF;
      end else if ({3'b000, n} == last) begin
         value = 32'hFFFF_FFFF;
      end else if ({3'b000, n} < last) begin
         value = 32'(n) + 32'd1;
      end
      return value;
   endfunction

   // chunk contents per sector class
   always_comb begin
      logic [31:0] entry;
      logic [22:0] pos;
      for (int k = 0; k < 16; k++) begin
         b[k] = 8'h00;
      end
      entry = 32'h0;
      pos   = '0;
      case (job.region)
         REGION_MBR: begin
            if (job.chunk == 5'd28) begin
               b[2]  = 8'h0C;
               b[6]  = SECT_BOOT[7:0];
               b[11] = 8'h10;
            end
            if (job.chunk == 5'd31) begin
               b[14] = 8'h55;
               b[15] = 8'hAA;
            end
         end
         REGION_BOOT: begin
            case (job.chunk)
               5'd0: begin
                  b[0] = 8'hEB; b[1] = 8'h58; b[2] = 8'h90; b[3] = 8'h4D;
                  b[4] = 8'h53; b[5] = 8'h44; b[6] = 8'h4F; b[7] = 8'h53;
                  b[8] = 8'h35; b[9] = 8'h2E; b[10] = 8'h30; b[11] = 8'h00;
                  b[12] = 8'h02; b[13] = 8'h08; b[14] = 8'h01; b[15] = 8'h00;
               end
               5'd1: begin
                  b[0] = 8'h02; b[5] = 8'hF8; b[8] = 8'h3F; b[10] = 8'hFF;
                  b[12] = SECT_BOOT[7:0];
               end
               5'd2: begin
                  b[1] = 8'h10; b[4] = 8'h08; b[12] = 8'h02;
               end
               5'd3: begin
                  b[0] = 8'h01; b[2] = 8'h06;
               end
               5'd4: begin
                  b[0] = 8'h80; b[1] = 8'h00; b[2] = 8'h29; b[3] = 8'h94;
                  b[4] = 8'h0E; b[5] = 8'h0D; b[6] = 8'h08; b[7] = 8'h4E;
                  b[8] = 8'h4F; b[9] = 8'h20; b[10] = 8'h4E; b[11] = 8'h41;
                  b[12] = 8'h4D; b[13] = 8'h45; b[14] = 8'h20; b[15] = 8'h20;
               end
               5'd5: begin
                  b[0] = 8'h20; b[1] = 8'h20; b[2] = 8'h46; b[3] = 8'h41;
                  b[4] = 8'h54; b[5] = 8'h33; b[6] = 8'h32; b[7] = 8'h20;
                  b[8] = 8'h20; b[9] = 8'h20;
               end
               5'd31: begin
                  b[14] = 8'h55; b[15] = 8'hAA;
               end
               default: begin
               end
            endcase
         end
         REGION_FAT: begin
            // four little-endian entries per chunk
            for (int e = 0; e < 4; e++) begin
               entry = fat_entry({job.fat_base[9:2], 2'(e)}, chain_end);
               b[4*e]     = entry[7:0];
               b[4*e + 1] = entry[15:8];
               b[4*e + 2] = entry[23:16];
               b[4*e + 3] = entry[31:24];
            end
         end
         REGION_ROOT: begin
            if (job.chunk == 5'd0) begin
               // volume label entry
               b[0] = 8'h4C; b[1] = 8'h55; b[2] = 8'h46; b[3] = 8'h41;
               b[4] = 8'h5F; b[5] = 8'h31; b[6] = 8'h20; b[7] = 8'h20;
               b[8] = 8'h20; b[9] = 8'h20; b[10] = 8'h20; b[11] = 8'h08;
            end else if (job.chunk == 5'd2) begin
               // file name and attribute
               b[0] = 8'h4B; b[1] = 8'h45; b[2] = 8'h59; b[3] = 8'h5F;
               b[4] = 8'h46; b[5] = 8'h49; b[6] = 8'h4C; b[7] = 8'h45;
               b[8] = 8'h54; b[9] = 8'h58; b[10] = 8'h54; b[11] = 8'h20;
               b[13] = 8'h04; b[14] = 8'h72;
            end else if (job.chunk == 5'd3) begin
               // dates, first cluster and size
               b[0] = 8'h79; b[1] = 8'h40; b[2] = 8'h79; b[3] = 8'h40;
               b[8] = 8'h79; b[9] = 8'h40;
               b[10] = first_cluster;
               b[12] = file_size[7:0];
               b[13] = file_size[15:8];
               b[14] = {1'b0, file_size[22:16]};
            end
         end
         REGION_FILE: begin
            if (file_hit) begin
               for (int k = 0; k < 16; k++) begin
                  pos = {job.offset[22:4], 4'(k)};
                  if (pos < 23'(RomLen) && 32'(pos) < KEY_BYTES) begin
                     b[k] = key_byte(pos[5:0]);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   // pack bytes into the response
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         rsp_data_in.data_low[8*k +: 8]  = b[k];
         rsp_data_in.data_high[8*k +: 8] = b[k + 8];
      end
      rsp_strobe_in = job_valid;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* rtl/fvd_checker.sv */
// port-level checks for the fat32 sector generator, bound to the top level
// depends on fvd_pkg and assert_macros.svh
`include "assert_macros.svh"

module fvd_checker
   import fvd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic sig_req;

   // request for the chunk that carries the mbr signature
   assign sig_req = start && !busy && req_data.block_address == SECT_MBR &&
                    req_data.chunk_index == 5'd31;

   // the back end drains every cycle, so requests are never held off once out of reset
   `ASSERT_IMPLIES(a_never_busy, clock, reset, !reset, !busy)

   // every request gets its response after the front stage, queue entry and output register
   `ASSERT_IMPLIES(a_rsp_follows_req, clock, reset, start && !busy, ##3 rsp_strobe)

   // no response without an earlier request
   `ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_strobe, $past(start && !busy, 3))

   // the mbr signature comes back in the last chunk of sector zero
   `ASSERT_IMPLIES(a_mbr_signature, clock, reset, sig_req, ##3 (rsp_data.data_high[63:48] == 16'hAA55))

   // reset silences the strobe
   `ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_strobe)

endmodule

bind fat32_virtual_disk_sector_generator fvd_checker u_fvd_checker (.*);

/* tb/fat32_virtual_disk_sector_generator_test.sv */
// self-checking testbench for the fat32 sector generator: scoreboard class, drivers, monitor
// depends on fvd_pkg and fat32_virtual_disk_sector_generator
// predicts every 16-byte chunk of the image from the sector map and the file size register
module fat32_virtual_disk_sector_generator_test;
   import fvd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KeyBytes     = 38;
   localparam int KeyRomLength = 38;
   localparam int CycleLimit   = 50000;
   localparam int RandomCount  = 37;

   // scoreboard: own copy of the size register and the chunks still to come
   class fat_image_scoreboard;
      logic [22:0] file_size_copy;
      rsp_type     expected_chunks[$];
      int unsigned failures;

      localparam logic [8*KeyRomLength-1:0] KEY_TEXT =
         "{7065c23a-3818-43c5-bdf0-55567ade31e7}";

      function new();
         file_size_copy = 23'd38;
         failures = 0;
      endfunction

      function void restore_size();
         file_size_copy = 23'd38;
      endfunction

      function void take_size(input logic [22:0] v);
         file_size_copy = v;
      endfunction

      function int unsigned pending_count();
         return expected_chunks.size();
      endfunction

      // constants below are written first byte leftmost
      function logic [127:0] in_text_order(input logic [127:0] v);
         logic [127:0] flipped;
         int k;
         for (k = 0; k < 16; k++) flipped[k*8 +: 8] = v[(15-k)*8 +: 8];
         return flipped;
      endfunction

      // 16 bytes of the disk image at one sector and chunk
      function rsp_type image_chunk(input req_type r);
         logic [15:0][7:0] b;
         logic [23:0] ba;
         int unsigned ch, rel, n, entry, first, clusters, k;
         longint unsigned off, limit, p;
         ba = r.block_address;
         ch = r.chunk_index;
         b = '0;
         clusters = (int'(file_size_copy) + 4095) / 4096;
         first = (file_size_copy == 0) ? 0 : 3;
         if (ba == SECT_MBR) begin
            // partition entry and signature
            if (ch == 28) begin
               b[2] = 8'h0C;
               b[6] = SECT_BOOT[7:0];
               b[11] = 8'h10;
            end
            if (ch == 31) begin
               b[14] = 8'h55;
               b[15] = 8'hAA;
            end
         end else if (ba == SECT_BOOT) begin
            case (ch)
               0: b = in_text_order(128'hEB58904D_53444F53_352E3000_02080100);
               1: begin
                  b[0] = 8'h02; b[5] = 8'hF8; b[8] = 8'h3F; b[10] = 8'hFF;
                  b[12] = SECT_BOOT[7:0];
               end
               2: begin
                  b[1] = 8'h10; b[4] = 8'h08; b[12] = 8'h02;
               end
               3: begin
                  b[0] = 8'h01; b[2] = 8'h06;
               end
               4: b = in_text_order(128'h80002994_0E0D084E_4F204E41_4D452020);
               5: b = in_text_order(128'h20204641_54333220_20200000_00000000);
               31: begin
                  b[14] = 8'h55; b[15] = 8'hAA;
               end
               default: ;
            endcase
         end else if (ba >= SECT_FAT1 && ba < SECT_ROOT) begin
            // four fat entries, both copies identical
            rel = (ba < SECT_FAT2) ? int'(ba - SECT_FAT1) : int'(ba - SECT_FAT2);
            for (k = 0; k < 4; k++) begin
               n = rel * 128 + ch * 4 + k;
               if (n < 2) entry = 32'hFFFF_FFF8;
               else if (n == 2 || n == 2 + clusters) entry = 32'hFFFF_FFFF;
               else if (n < 2 + clusters) entry = n + 1;
               else entry = 0;
               b[4*k +: 4] = entry;
            end
         end else if (ba == SECT_ROOT) begin
            if (ch == 0) begin
               b = in_text_order(128'h4C554641_5F312020_20202008_00000000);
            end else if (ch == 2) begin
               b = in_text_order(128'h4B45595F_46494C45_54585420_00047200);
            end else if (ch == 3) begin
               // dates, first cluster split high and low, size
               b[0] = 8'h79; b[1] = 8'h40; b[2] = 8'h79; b[3] = 8'h40;
               b[4] = first[23:16]; b[5] = first[31:24];
               b[8] = 8'h79; b[9] = 8'h40;
               b[10] = first[7:0]; b[11] = first[15:8];
               b[15:12] = 32'(file_size_copy);
            end
         end else if (ba >= SECT_FILE) begin
            // file data, zero past the end of the file or its last cluster
            off = longint'(ba - SECT_FILE) * 512 + longint'(ch) * 16;
            limit = longint'(clusters) * 4096;
            if (!(off > longint'(file_size_copy) || off >= limit)) begin
               for (k = 0; k < 16; k++) begin
                  p = off + k;
                  if (p < KeyBytes && p < KeyRomLength)
                     b[k] = KEY_TEXT[(KeyRomLength - 1 - int'(p)) * 8 +: 8];
               end
            end
         end
         return rsp_type'(b);
      endfunction

      function void note_request(input req_type r);
         expected_chunks.push_back(image_chunk(r));
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (expected_chunks.size() == 0) begin
            $error("response with no request outstanding: %h", got);
            failures++;
            return;
         end
         want = expected_chunks.pop_front();
         if (got.data_low !== want.data_low) begin
            $error("data_low: expected %h, got %h", want.data_low, got.data_low);
            failures++;
         end
         if (got.data_high !== want.data_high) begin
            $error("data_high: expected %h, got %h", want.data_high, got.data_high);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [22:0] csr_write_data = '0;

   fat_image_scoreboard board;
   logic [22:0]         current_size = 23'd38;
   bit                  steady_stretch = 1'b0;
   int unsigned         cycle_count = 0;

   fat32_virtual_disk_sector_generator #(
      .KEY_BYTES(KeyBytes)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // monitor: size writes, accepted requests, responses
   always @(posedge clock) begin
      if (reset) begin
         board.restore_size();
      end else begin
         if (csr_write_enable === 1'b1) board.take_size(csr_write_data);
         if (start === 1'b1 && busy === 1'b0) board.note_request(req_data);
         if (rsp_strobe === 1'b1) board.check_response(rsp_data);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic req_type make_request(input logic [23:0] ba, input logic [4:0] ch);
      req_type r;
      r.block_address = ba;
      r.chunk_index = ch;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      if (steady_stretch || $urandom_range(99) >= 14) return 0;
      return $urandom_range(6, 1);
   endfunction

   // weighted towards the populated sectors and the edges of the file
   function automatic req_type pick_request(input logic [22:0] fsize);
      req_type r;
      int unsigned sel, chain_end, last_sect;
      int ch;
      sel = $urandom_range(99);
      r.block_address = 24'($urandom());
      r.chunk_index = 5'($urandom());
      chain_end = 2 + (int'(fsize) + 4095) / 4096;
      last_sect = int'(fsize) / 512;
      if (sel < 10) begin
         r.block_address = SECT_MBR;
         if ($urandom_range(1)) r.chunk_index = $urandom_range(1) ? 5'd28 : 5'd31;
      end else if (sel < 20) begin
         r.block_address = SECT_BOOT;
         if ($urandom_range(1)) r.chunk_index = 5'($urandom_range(5));
      end else if (sel < 45) begin
         // half of the fat reads land on the end of the cluster chain when it lies in the fat
         if ($urandom_range(1) && chain_end < 1024) begin
            r.block_address = SECT_FAT1 + 24'(chain_end / 128)
                              + ($urandom_range(1) ? 24'd8 : 24'd0);
            r.chunk_index = 5'((chain_end % 128) / 4);
         end else begin
            r.block_address = SECT_FAT1 + 24'($urandom_range(15));
         end
      end else if (sel < 60) begin
         r.block_address = SECT_ROOT + (($urandom_range(3) == 0) ? 24'($urandom_range(7)) : 24'd0);
         if ($urandom_range(9) < 7) r.chunk_index = 5'($urandom_range(3));
      end else if (sel < 88) begin
         case ($urandom_range(2))
            0: r.block_address = SECT_FILE + 24'($urandom_range(1));
            1: begin
               // around the last byte of the file
               r.block_address = SECT_FILE + 24'(last_sect);
               ch = (int'(fsize) % 512) / 16 + int'($urandom_range(2)) - 1;
               if (ch < 0) ch = 0;
               if (ch > 31) ch = 31;
               r.chunk_index = 5'(ch);
            end
            default: r.block_address = SECT_FILE + 24'($urandom_range(last_sect + 16));
         endcase
      end
      return r;
   endfunction

   // one request, with an occasional idle gap before it
   task automatic send_request(input req_type r);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // drain, then write the size register while the block is idle
   task automatic write_size(input logic [22:0] v);
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      current_size = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_directed();
      req_type plan[$];
      // mbr partition entry, signature and an empty chunk
      plan.push_back(make_request(SECT_MBR, 5'd28));
      plan.push_back(make_request(SECT_MBR, 5'd31));
      plan.push_back(make_request(SECT_MBR, 5'd0));
      // boot sector fields
      for (int c = 0; c < 6; c++) plan.push_back(make_request(SECT_BOOT, 5'(c)));
      plan.push_back(make_request(SECT_BOOT, 5'd31));
      // first and last chunk of both fat copies
      plan.push_back(make_request(SECT_FAT1, 5'd0));
      plan.push_back(make_request(SECT_FAT2 - 24'd1, 5'd31));
      plan.push_back(make_request(SECT_FAT2, 5'd0));
      plan.push_back(make_request(SECT_ROOT - 24'd1, 5'd31));
      // root directory entries
      for (int c = 0; c < 4; c++) plan.push_back(make_request(SECT_ROOT, 5'(c)));
      // key data and the zero tail after it
      for (int c = 0; c < 4; c++) plan.push_back(make_request(SECT_FILE, 5'(c)));
      // unused sectors and the top of the address range
      plan.push_back(make_request(24'd1, 5'd0));
      plan.push_back(make_request(SECT_BOOT - 24'd1, 5'd15));
      plan.push_back(make_request(SECT_ROOT + 24'd1, 5'd5));
      plan.push_back(make_request(24'hFF_FFFF, 5'd31));
      foreach (plan[i]) send_request(plan[i]);
   endtask

   task automatic run_random(input int unsigned count);
      for (int i = 0; i < count; i++) send_request(pick_request(current_size));
   endtask

   initial begin
      logic [22:0] sizes[$];
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset value of the size register first
      run_directed();
      run_random(RandomCount);

      // empty file, largest file, cluster edges, chain end hidden past the fat
      sizes = '{23'd0, 23'd4194304, 23'd1, 23'd15, 23'd16, 23'd37, 23'd39,
                23'd4096, 23'd4097, 23'd524288, 23'd4182016,
                23'($urandom_range(4194304)), 23'd38};
      foreach (sizes[i]) begin
         steady_stretch = (i == 4);
         write_size(sizes[i]);
         run_random(RandomCount);
      end
      steady_stretch = 1'b0;

      // let the last responses come through
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_count() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
